// ===== rtl/core/word_wrap_text_layout_core_macros.svh =====
// Assertion macros for the word wrap text layout core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef WORD_WRAP_TEXT_LAYOUT_CORE_MACROS_SVH
`define WORD_WRAP_TEXT_LAYOUT_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define WWL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Expression must never be true at a clock edge outside reset.
`define WWL_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");

`else

`define WWL_ASSERT(lbl, clk, rst_n, prop)
`define WWL_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ===== rtl/core/wwl_pkg.sv =====
// Shared types, constants and glyph functions of the word wrap text layout core.
// No dependencies; used by the layout controller, the glyph emitter and the top level.
package wwl_pkg;

	localparam int COORD_W   = 12;
	localparam int COORD_MAX = 4095;
	localparam int PIX_MAX   = 1023;
	localparam int CELL      = 12;
	localparam int SPACING   = 2;
	localparam int GW_MAX    = 12;

	// Glyph widths of the proportional font, indexed by character code.
	localparam logic [3:0] GLYPH_W [128] = '{
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
		4'd2, 4'd2, 4'd4, 4'd8, 4'd6, 4'd10, 4'd9, 4'd2,
		4'd4, 4'd4, 4'd6, 4'd6, 4'd2, 4'd6, 4'd2, 4'd6,
		4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
		4'd6, 4'd6, 4'd2, 4'd2, 4'd5, 4'd6, 4'd5, 4'd6,
		4'd10, 4'd8, 4'd7, 4'd8, 4'd8, 4'd7, 4'd7, 4'd8,
		4'd7, 4'd6, 4'd9, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8,
		4'd7, 4'd9, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd10,
		4'd8, 4'd8, 4'd8, 4'd4, 4'd6, 4'd4, 4'd6, 4'd7,
		4'd3, 4'd6, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6, 4'd6,
		4'd6, 4'd2, 4'd5, 4'd6, 4'd2, 4'd8, 4'd6, 4'd6,
		4'd6, 4'd6, 4'd5, 4'd6, 4'd4, 4'd6, 4'd6, 4'd10,
		4'd6, 4'd6, 4'd6, 4'd4, 4'd2, 4'd4, 4'd8, 4'd0
	};

	// Command from the layout controller to the glyph emitter.
	typedef struct packed {
		logic               start;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               full;
	} wwl_emit_cmd_t;

	// Horizontal advance of a glyph: table width plus spacing.
	function automatic logic [3:0] glyph_adv(input logic [6:0] c);
		return 4'(GLYPH_W[c] + 4'(SPACING));
	endfunction

	function automatic logic [7:0] sheet_col(input logic [6:0] c);
		return 8'(CELL) * {4'b0, c[3:0]};
	endfunction

	function automatic logic [6:0] sheet_row(input logic [6:0] c);
		return 7'(CELL) * {4'b0, c[6:4]};
	endfunction

endpackage

// ===== rtl/core/wwl_word_mem.sv =====
// Word store: simple dual-port synchronous RAM holding the characters of the pending word.
// One write port, one read port with registered read data. No package dependencies.
module wwl_word_mem #(
	parameter int WORD_MAX = 64,
	localparam int AW = $clog2(WORD_MAX)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [6:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [6:0]    rdata
);

	logic [6:0] mem [WORD_MAX];
	logic [6:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/wwl_emit.sv =====
// Glyph emitter: reads one word store entry per cycle unless out_stall holds it; drives the placements.
// Depends on wwl_pkg and the assertion macros header.
`include "word_wrap_text_layout_core_macros.svh"

module wwl_emit #(
	parameter int WORD_MAX = 64,
	localparam int AW = $clog2(WORD_MAX),
	localparam int CW = $clog2(WORD_MAX + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wwl_pkg::wwl_emit_cmd_t cmd,
	input  logic [CW-1:0]         cmd_len,
	output logic                  busy,
	output logic                  mem_re,
	output logic [AW-1:0]         mem_raddr,
	input  logic [6:0]            mem_rdata,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [11:0]           place_x,
	output logic [11:0]           place_y,
	output logic [7:0]            sheet_x,
	output logic [6:0]            sheet_y,
	output logic [3:0]            glyph_width,
	output logic                  last_glyph,
	output logic                  area_full
);

	logic          active_q;
	logic [CW-1:0] left_q;
	logic [AW-1:0] rd_idx_q;
	logic [11:0]   px_q;
	logic [11:0]   y_q;
	logic          full_q;
	logic          s1_valid_s1;
	logic          s1_last_s1;
	logic          out_valid_q;
	logic [11:0]   place_x_q;
	logic [11:0]   place_y_q;
	logic [7:0]    sheet_x_q;
	logic [6:0]    sheet_y_q;
	logic [3:0]    glyph_width_q;
	logic          last_glyph_q;
	logic          area_full_q;

	logic          out_free;
	logic          issue;
	logic          load;
	logic [3:0]    gw;
	logic [12:0]   px_sum;

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		issue    = active_q && (!s1_valid_s1 || out_free);
		load     = s1_valid_s1 && out_free;
		gw       = wwl_pkg::glyph_adv(mem_rdata);
		px_sum   = {1'b0, px_q} + 13'(gw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			left_q      <= '0;
			rd_idx_q    <= '0;
			s1_valid_s1 <= 1'b0;
			s1_last_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				active_q <= 1'b1;
				left_q   <= cmd_len;
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= AW'(rd_idx_q + 1'b1);
				left_q   <= left_q - 1'b1;
				if (left_q == CW'(1)) begin
					active_q <= 1'b0;
				end
			end

			if (issue) begin
				s1_valid_s1 <= 1'b1;
				s1_last_s1  <= (left_q == CW'(1));
			end else if (load) begin
				s1_valid_s1 <= 1'b0;
			end

			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_free) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: start position on a new word, advance per placed glyph.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q   <= cmd.x;
			y_q    <= cmd.y;
			full_q <= cmd.full;
		end else if (load) begin
			px_q <= px_sum[12] ? 12'(wwl_pkg::COORD_MAX) : px_sum[11:0];
		end
		if (load) begin
			place_x_q     <= px_q;
			place_y_q     <= y_q;
			sheet_x_q     <= wwl_pkg::sheet_col(mem_rdata);
			sheet_y_q     <= wwl_pkg::sheet_row(mem_rdata);
			glyph_width_q <= gw;
			last_glyph_q  <= s1_last_s1;
			area_full_q   <= full_q;
		end
	end

	assign busy        = active_q || s1_valid_s1;
	assign mem_re      = issue;
	assign mem_raddr   = rd_idx_q;
	assign out_valid   = out_valid_q;
	assign place_x     = place_x_q;
	assign place_y     = place_y_q;
	assign sheet_x     = sheet_x_q;
	assign sheet_y     = sheet_y_q;
	assign glyph_width = glyph_width_q;
	assign last_glyph  = last_glyph_q;
	assign area_full   = area_full_q;

	`WWL_NEVER(a_start_while_busy, clk, arst_n, cmd.start && busy)
	`WWL_ASSERT(a_held_read_kept, clk, arst_n, (s1_valid_s1 && !out_free) |=> s1_valid_s1)
	`WWL_ASSERT(a_active_has_work, clk, arst_n, active_q |-> (left_q != '0))

endmodule

// ===== rtl/core/wwl_layout.sv =====
// Layout controller: takes characters, fills the word store and moves the text cursor.
// Depends on wwl_pkg and the assertion macros header.
`include "word_wrap_text_layout_core_macros.svh"

module wwl_layout #(
	parameter int WORD_MAX    = 64,
	parameter int LINE_HEIGHT = 12,
	parameter int TAB_STEP    = 48,
	localparam int AW = $clog2(WORD_MAX),
	localparam int CW = $clog2(WORD_MAX + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [6:0]             char_code,
	input  logic                   end_of_text,
	input  logic [11:0]            area_left,
	input  logic [11:0]            area_top,
	input  logic [11:0]            area_width,
	input  logic [11:0]            area_height,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [6:0]             mem_wdata,
	output wwl_pkg::wwl_emit_cmd_t emit_cmd,
	output logic [CW-1:0]          emit_len,
	input  logic                   emit_busy
);

	localparam int SW     = $clog2(WORD_MAX * wwl_pkg::GW_MAX + 1);
	localparam int XW     = ((SW > 12) ? SW : 12) + 1;
	localparam int TAB_SH = 20;
	localparam int TAB_M  = ((1 << TAB_SH) + TAB_STEP - 1) / TAB_STEP;

	localparam logic [6:0] CH_TAB   = 7'd9;
	localparam logic [6:0] CH_LF    = 7'd10;
	localparam logic [6:0] CH_CR    = 7'd13;
	localparam logic [6:0] CH_SPACE = 7'd32;

	typedef enum logic [2:0] {
		L_IDLE, L_FIT, L_BOT, L_MOVE, L_TAB1, L_TAB2, L_EDGE, L_BOT2
	} layout_state_t;

	typedef enum logic [1:0] {MV_SPACE, MV_TAB, MV_LF, MV_CR} move_kind_t;

	layout_state_t          state_q;
	move_kind_t             kind_q;
	logic                   open_q;
	logic                   stop_q;
	logic                   mv_pend_q;
	logic                   em_pend_q;
	logic                   ov_q;
	logic [11:0]            x_q;
	logic [11:0]            y_q;
	logic [CW-1:0]          len_q;
	logic [SW-1:0]          sum_q;
	logic [11:0]            q_q;
	logic [11:0]            base_q;
	wwl_pkg::wwl_emit_cmd_t em_cmd_q;
	logic [CW-1:0]          em_len_q;

	logic                   accept;
	logic [11:0]            x_e;
	logic [11:0]            y_e;
	logic                   stop_e;
	logic [CW-1:0]          len_e;
	logic [SW-1:0]          sum_e;
	logic                   is_ws;
	move_kind_t             kind_in;
	logic [CW-1:0]          len_inc;
	logic [SW-1:0]          sum_inc;
	logic [12:0]            lf;
	logic [9:0]             pix;
	logic signed [13:0]     room;
	logic                   fit_wrap;
	logic                   bottom;
	logic                   at_edge;
	logic [XW-1:0]          x_sum;
	logic [11:0]            x_end;
	logic [12:0]            sp_nx;
	logic [31:0]            tab_prod;
	logic [12:0]            tab_nx;

	// Add one line; MSB of the result flags overflow past the coordinate range.
	function automatic logic [12:0] line_feed(input logic [11:0] y);
		logic [12:0] s;
		s = {1'b0, y} + 13'(LINE_HEIGHT);
		return s[12] ? {1'b1, 12'(wwl_pkg::COORD_MAX)} : s;
	endfunction

	always_comb begin
		in_stall = (state_q != L_IDLE) || em_cmd_q.start || emit_busy;
		accept   = in_valid && !in_stall;

		// A new text starts from the rectangle's corner with an empty word.
		x_e    = open_q ? x_q : area_left;
		y_e    = open_q ? y_q : area_top;
		stop_e = open_q && stop_q;
		len_e  = open_q ? len_q : '0;
		sum_e  = open_q ? sum_q : '0;

		is_ws   = 1'b1;
		kind_in = MV_SPACE;
		unique case (char_code)
			CH_SPACE: kind_in = MV_SPACE;
			CH_TAB:   kind_in = MV_TAB;
			CH_LF:    kind_in = MV_LF;
			CH_CR:    kind_in = MV_CR;
			default:  is_ws = 1'b0;
		endcase

		len_inc = len_e + 1'b1;
		sum_inc = sum_e + SW'(wwl_pkg::glyph_adv(char_code));

		lf   = line_feed(y_q);
		pix  = (XW'(sum_q) > XW'(wwl_pkg::PIX_MAX)) ? 10'(wwl_pkg::PIX_MAX) : 10'(sum_q);
		room = $signed({2'b0, area_left}) + $signed({2'b0, area_width})
			- $signed({2'b0, x_q});
		fit_wrap = $signed({4'b0, pix}) > room;
		bottom   = ($signed({2'b0, y_q}) - $signed({2'b0, area_top}))
			>= $signed({2'b0, area_height});
		at_edge  = ($signed({2'b0, x_q}) - $signed({2'b0, area_left}))
			>= $signed({2'b0, area_width});

		x_sum = XW'(x_q) + XW'(sum_q);
		x_end = (x_sum > XW'(wwl_pkg::COORD_MAX)) ? 12'(wwl_pkg::COORD_MAX) : x_sum[11:0];

		sp_nx = {1'b0, x_q} + 13'(wwl_pkg::glyph_adv(CH_SPACE));
		// Reciprocal quotient is exact for 12-bit x when TAB_STEP is at most 256.
		tab_prod = 32'(x_q) * 32'(TAB_M);
		tab_nx   = {1'b0, base_q} + 13'(TAB_STEP);

		mem_we    = accept && !stop_e && !is_ws;
		mem_waddr = len_e[AW-1:0];
		mem_wdata = char_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= L_IDLE;
			kind_q    <= MV_SPACE;
			open_q    <= 1'b0;
			stop_q    <= 1'b0;
			mv_pend_q <= 1'b0;
			em_pend_q <= 1'b0;
			ov_q      <= 1'b0;
			x_q       <= '0;
			y_q       <= '0;
			len_q     <= '0;
			sum_q     <= '0;
			q_q       <= '0;
			base_q    <= '0;
			em_cmd_q  <= '0;
			em_len_q  <= '0;
		end else begin
			em_cmd_q.start <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (accept) begin
						open_q <= !end_of_text;
						x_q    <= x_e;
						y_q    <= y_e;
						stop_q <= stop_e;
						len_q  <= len_e;
						sum_q  <= sum_e;
						kind_q <= kind_in;
						if (!stop_e) begin
							em_pend_q <= 1'b0;
							if (is_ws) begin
								mv_pend_q <= 1'b1;
								state_q   <= (len_e != '0) ? L_FIT : L_MOVE;
							end else begin
								len_q     <= len_inc;
								sum_q     <= sum_inc;
								mv_pend_q <= 1'b0;
								if (len_inc == CW'(WORD_MAX) || end_of_text) begin
									state_q <= L_FIT;
								end
							end
						end
					end
				end
				L_FIT: begin
					if (fit_wrap) begin
						x_q    <= area_left;
						y_q    <= lf[11:0];
						stop_q <= stop_q || lf[12];
					end
					state_q <= L_BOT;
				end
				L_BOT: begin
					len_q <= '0;
					sum_q <= '0;
					if (stop_q || bottom) begin
						stop_q  <= 1'b1;
						state_q <= L_IDLE;
					end else begin
						em_cmd_q.x <= x_q;
						em_cmd_q.y <= y_q;
						em_len_q   <= len_q;
						em_pend_q  <= 1'b1;
						x_q        <= x_end;
						if (mv_pend_q) begin
							state_q <= L_MOVE;
						end else begin
							em_cmd_q.start <= 1'b1;
							em_cmd_q.full  <= 1'b0;
							state_q        <= L_IDLE;
						end
					end
				end
				L_MOVE: begin
					ov_q    <= 1'b0;
					state_q <= L_EDGE;
					unique case (kind_q)
						MV_LF: begin
							y_q    <= lf[11:0];
							stop_q <= stop_q || lf[12];
						end
						MV_CR: begin
							x_q <= area_left;
						end
						MV_SPACE: begin
							if (sp_nx[12]) begin
								ov_q <= 1'b1;
							end else begin
								x_q <= sp_nx[11:0];
							end
						end
						MV_TAB: begin
							q_q     <= tab_prod[TAB_SH +: 12];
							state_q <= L_TAB1;
						end
						default: state_q <= L_EDGE;
					endcase
				end
				L_TAB1: begin
					base_q  <= 12'(32'(q_q) * 32'(TAB_STEP));
					state_q <= L_TAB2;
				end
				L_TAB2: begin
					if (tab_nx[12]) begin
						ov_q <= 1'b1;
					end else begin
						x_q <= tab_nx[11:0];
					end
					state_q <= L_EDGE;
				end
				L_EDGE: begin
					if (ov_q || at_edge) begin
						x_q    <= area_left;
						y_q    <= lf[11:0];
						stop_q <= stop_q || lf[12];
					end
					state_q <= L_BOT2;
				end
				L_BOT2: begin
					stop_q <= stop_q || bottom;
					if (em_pend_q) begin
						em_cmd_q.start <= 1'b1;
						em_cmd_q.full  <= stop_q || bottom;
					end
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign emit_cmd = em_cmd_q;
	assign emit_len = em_len_q;

	`WWL_ASSERT(a_emit_nonempty, clk, arst_n, em_cmd_q.start |-> (em_len_q != '0))
	`WWL_ASSERT(a_word_room, clk, arst_n, (state_q == L_IDLE) |-> (len_q < CW'(WORD_MAX)))

endmodule

// ===== rtl/core/word_wrap_text_layout_core.sv =====
// Top level of the word wrap text layout core: configuration registers and unit wiring.
// Depends on wwl_pkg, wwl_word_mem, wwl_emit and wwl_layout.
//
// Lays out a stream of 7-bit characters as proportional glyphs inside the rectangle given
// by area_left/area_top/area_width/area_height (register indexes 0 to 3, reset 0, 0, 640,
// 480; write them only while no text transaction is in flight). Word characters go into
// a WORD_MAX-entry word store. A word is flushed on whitespace, on end_of_text or when the
// store fills: the cursor logic fits the word in its fit and bottom-check states (wrapping
// to a new line if needed), then the emitter reads the store through its single read port
// and produces one placement transaction per cycle while the output is not stalled, after
// a registered read of the store. Space, CR and LF pass through the move, edge and bottom
// states of cursor work, and tab also through the tab states (a reciprocal multiply and a
// multiply back). The input is stalled during all of this. Placements can wait in the
// output register while the next word is buffered. The word store comes out of reset with
// undefined contents and needs no clearing pass: only entries written earlier in the same
// word are read. Once the cursor passes the bottom edge, the rest of the text yields no
// placements until the transaction marked end_of_text closes it.
module word_wrap_text_layout_core #(
	parameter int WORD_MAX    = 64,
	parameter int LINE_HEIGHT = 12,
	parameter int TAB_STEP    = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	// character input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [6:0]  char_code,
	input  logic        end_of_text,
	// glyph placement output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] place_x,
	output logic [11:0] place_y,
	output logic [7:0]  sheet_x,
	output logic [6:0]  sheet_y,
	output logic [3:0]  glyph_width,
	output logic        last_glyph,
	output logic        area_full
);

	localparam int AW = $clog2(WORD_MAX);
	localparam int CW = $clog2(WORD_MAX + 1);

	localparam logic [1:0] REG_AREA_LEFT   = 2'd0;
	localparam logic [1:0] REG_AREA_TOP    = 2'd1;
	localparam logic [1:0] REG_AREA_WIDTH  = 2'd2;
	localparam logic [1:0] REG_AREA_HEIGHT = 2'd3;

	logic [11:0]            area_left_q;
	logic [11:0]            area_top_q;
	logic [11:0]            area_width_q;
	logic [11:0]            area_height_q;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [6:0]             mem_wdata;
	logic                   mem_re;
	logic [AW-1:0]          mem_raddr;
	logic [6:0]             mem_rdata;
	wwl_pkg::wwl_emit_cmd_t emit_cmd;
	logic [CW-1:0]          emit_len;
	logic                   emit_busy;

	// Registers take a write in any cycle; software keeps writes to idle periods.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_left_q   <= 12'd0;
			area_top_q    <= 12'd0;
			area_width_q  <= 12'd640;
			area_height_q <= 12'd480;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_AREA_LEFT:   area_left_q   <= cfg_data;
				REG_AREA_TOP:    area_top_q    <= cfg_data;
				REG_AREA_WIDTH:  area_width_q  <= cfg_data;
				REG_AREA_HEIGHT: area_height_q <= cfg_data;
				default:         area_left_q   <= area_left_q;
			endcase
		end
	end

	// Cursor and word buffering: owns the write side of the word store.
	wwl_layout #(
		.WORD_MAX    (WORD_MAX),
		.LINE_HEIGHT (LINE_HEIGHT),
		.TAB_STEP    (TAB_STEP)
	) u_layout (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.area_left   (area_left_q),
		.area_top    (area_top_q),
		.area_width  (area_width_q),
		.area_height (area_height_q),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.emit_cmd    (emit_cmd),
		.emit_len    (emit_len),
		.emit_busy   (emit_busy)
	);

	// Pending word characters; written one per accepted word character until the layout stops.
	wwl_word_mem #(
		.WORD_MAX (WORD_MAX)
	) u_word_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Walk the stored word and drive one placement per glyph.
	wwl_emit #(
		.WORD_MAX (WORD_MAX)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (emit_cmd),
		.cmd_len     (emit_len),
		.busy        (emit_busy),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.place_x     (place_x),
		.place_y     (place_y),
		.sheet_x     (sheet_x),
		.sheet_y     (sheet_y),
		.glyph_width (glyph_width),
		.last_glyph  (last_glyph),
		.area_full   (area_full)
	);

endmodule
